FILE: hw/rtl/ptc_pkg.sv
// Shared types, constants and tables of the pan-tilt tracking command block.
package ptc_pkg;

  localparam int POS_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int VEL_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Z = 4'd3;

  // Turn status codes.
  localparam logic [1:0] TURN_RIGHT = 2'd0;
  localparam logic [1:0] TURN_HOLD  = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;
  localparam logic [1:0] TURN_NONE  = 2'd3;

  localparam logic [6:0] TILT_ANGLE = 7'd104;

  // Cubic PWM curve coefficients in units of 2^-40.
  localparam logic signed [59:0] K_C0 = 60'sd2499212484107;
  localparam logic signed [59:0] K_C1 = 60'sd3380276288918;
  localparam logic signed [59:0] K_C2 = 60'sd25447195739;
  localparam logic signed [59:0] K_C3 = 60'sd54993980;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORDIC, ST_PSI, ST_OMEGA, ST_GYPSI, ST_GXPSI, ST_VX, ST_VY, ST_VZ,
    ST_DECIDE, ST_BINIT, ST_MID, ST_C3, ST_C2, ST_C1, ST_HISGN, ST_BUPD, ST_HOLD,
    ST_OUT
  } ptc_state_e;

  typedef enum logic [3:0] {
    MUL_OMEGA, MUL_GYPSI, MUL_GXPSI, MUL_VX, MUL_VY, MUL_VZ, MUL_C3, MUL_C2, MUL_C1
  } ptc_mul_op_e;

  typedef struct packed {
    logic        capture;
    logic        cordic_step;
    logic [4:0]  cordic_idx;
    logic        psi_calc;
    logic        mul_start;
    ptc_mul_op_e mul_op;
    logic        decide;
    logic        bis_init;
    logic        mid_calc;
    logic        hi_sign;
    logic        bis_update;
    logic        hold_calc;
    logic        out_load;
  } ptc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic need_search;
  } ptc_sts_t;

  // CORDIC arctangent table in units of 2^-16 degree.
  function automatic logic [21:0] arc_angle(input logic [4:0] idx);
    case (idx)
      5'd0:  arc_angle = 22'd2949120;
      5'd1:  arc_angle = 22'd1740967;
      5'd2:  arc_angle = 22'd919879;
      5'd3:  arc_angle = 22'd466945;
      5'd4:  arc_angle = 22'd234379;
      5'd5:  arc_angle = 22'd117304;
      5'd6:  arc_angle = 22'd58666;
      5'd7:  arc_angle = 22'd29335;
      5'd8:  arc_angle = 22'd14668;
      5'd9:  arc_angle = 22'd7334;
      5'd10: arc_angle = 22'd3667;
      5'd11: arc_angle = 22'd1833;
      5'd12: arc_angle = 22'd917;
      5'd13: arc_angle = 22'd458;
      5'd14: arc_angle = 22'd229;
      5'd15: arc_angle = 22'd115;
      5'd16: arc_angle = 22'd57;
      5'd17: arc_angle = 22'd29;
      5'd18: arc_angle = 22'd14;
      5'd19: arc_angle = 22'd7;
      5'd20: arc_angle = 22'd4;
      5'd21: arc_angle = 22'd2;
      5'd22: arc_angle = 22'd1;
      default: arc_angle = 22'd0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/ptc_if.sv
// Handshake channel interfaces for target, command and configuration transactions.
interface ptc_target_if import ptc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface ptc_command_if import ptc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] robot_vel_x;
  logic signed [VEL_W-1:0] robot_vel_y;
  logic signed [VEL_W-1:0] robot_vel_z;
  logic [8:0]              pan_angle;
  logic [6:0]              tilt_angle;
  logic [8:0]              pan_speed;
  logic [1:0]              turn_status;
  modport source (output valid, robot_vel_x, robot_vel_y, robot_vel_z, pan_angle,
                  tilt_angle, pan_speed, turn_status, input ready);
  modport sink (input valid, robot_vel_x, robot_vel_y, robot_vel_z, pan_angle,
                tilt_angle, pan_speed, turn_status, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ptc_mul.sv
// Shared signed multiplier built from two narrow partial products computed in turn.
module ptc_mul import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] a_i,
  input  logic signed [26:0] b_i,
  output logic               done_o,
  output logic signed [74:0] prod_o
);

  logic signed [47:0] a_q;
  logic signed [26:0] b_q;
  logic signed [51:0] p_lo_q;
  logic signed [50:0] p_hi_q;
  logic signed [74:0] prod_q;
  logic v1_q, v2_q, v3_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (v1_q) begin
      p_lo_q <= $signed({1'b0, a_q[23:0]}) * b_q;
    end
    if (v2_q) begin
      p_hi_q <= $signed(a_q[47:24]) * b_q;
    end
    if (v3_q) begin
      prod_q <= (75'(p_hi_q) <<< 24) + 75'(p_lo_q);
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/ptc_dp.sv
// Datapath: configuration, CORDIC yaw angle, velocity terms and PWM bisection.
module ptc_dp import ptc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic signed [POS_W-1:0] in_x_i,
  input  logic signed [POS_W-1:0] in_y_i,
  input  logic signed [POS_W-1:0] in_z_i,
  input  ptc_cmd_t                cmd_i,
  output ptc_sts_t                sts_o,
  output logic signed [VEL_W-1:0] vel_x_o,
  output logic signed [VEL_W-1:0] vel_y_o,
  output logic signed [VEL_W-1:0] vel_z_o,
  output logic [8:0]              pan_angle_o,
  output logic [8:0]              pan_speed_o,
  output logic [1:0]              turn_status_o
);

  logic [15:0]        gain_q;
  logic signed [15:0] goal_x_q, goal_y_q, goal_z_q;
  logic [8:0]         held_q;

  logic signed [15:0] tx_q, ty_q, tz_q;
  logic signed [31:0] u_q, v_q;
  logic signed [23:0] z_q;
  logic signed [24:0] base_q;
  logic               origin_q;
  logic signed [16:0] psi_q;
  logic signed [33:0] omega_q;
  logic signed [33:0] err_x_q, err_y_q, err_z_q;
  logic signed [31:0] vel_x_q, vel_y_q, vel_z_q;
  logic [1:0]         status_q;
  logic signed [59:0] rate_c0_q;
  logic [24:0]        lo_q, hi_q, p_q;
  logic signed [35:0] b_q;
  logic signed [44:0] c_q;
  logic               sg_pos_q, sg_neg_q, hi_pos_q, hi_neg_q;
  ptc_mul_op_e        op_q;

  logic signed [31:0] ovx_q, ovy_q, ovz_q;
  logic [8:0]         opan_q, ospeed_q;
  logic [1:0]         ostat_q;

  logic signed [47:0] mul_a;
  logic signed [26:0] mul_b;
  logic               mul_done;
  logic signed [74:0] prod;

  logic signed [31:0] u_sh, v_sh;
  logic signed [23:0] arc;
  logic signed [23:0] z_eff;
  logic signed [26:0] fine;
  logic signed [26:0] psi_full;
  logic signed [16:0] dx, dy, dz;
  logic               omega_neg, omega_zero, omega_low;
  logic signed [33:0] rate_mag;
  logic [25:0]        mid_sum;
  logic [25:0]        speed_sum;
  logic signed [59:0] g_val;
  logic signed [18:0] pan_sum;
  logic signed [11:0] pan_sh;
  logic [8:0]         pan_clamped;

  function automatic logic signed [31:0] vel_sat(input logic signed [74:0] p);
    logic signed [49:0] t;
    logic signed [49:0] r;
    t = 50'sd262144 - 50'(p);
    r = t >>> 19;
    if (r > 50'sd2147483647) begin
      vel_sat = 32'sh7FFFFFFF;
    end else if (r < -50'sd2147483648) begin
      vel_sat = 32'sh80000000;
    end else begin
      vel_sat = r[31:0];
    end
  endfunction

  ptc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_comb begin
    case (cmd_i.mul_op)
      MUL_OMEGA: begin mul_a = 48'(psi_q);   mul_b = $signed({11'd0, gain_q}); end
      MUL_GYPSI: begin mul_a = 48'(psi_q);   mul_b = 27'(goal_y_q); end
      MUL_GXPSI: begin mul_a = 48'(psi_q);   mul_b = 27'(goal_x_q); end
      MUL_VX:    begin mul_a = 48'(err_x_q); mul_b = $signed({11'd0, gain_q}); end
      MUL_VY:    begin mul_a = 48'(err_y_q); mul_b = $signed({11'd0, gain_q}); end
      MUL_VZ:    begin mul_a = 48'(err_z_q); mul_b = $signed({11'd0, gain_q}); end
      MUL_C3:    begin mul_a = 48'(K_C3);    mul_b = $signed({2'd0, p_q}); end
      MUL_C2:    begin mul_a = 48'(b_q);     mul_b = $signed({2'd0, p_q}); end
      MUL_C1:    begin mul_a = 48'(c_q >>> 8); mul_b = $signed({2'd0, p_q}); end
      default:   begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  always_comb begin
    u_sh     = u_q >>> cmd_i.cordic_idx;
    v_sh     = v_q >>> cmd_i.cordic_idx;
    arc      = $signed({2'b00, arc_angle(cmd_i.cordic_idx)});
    // An origin target has no direction; its angle is taken as zero.
    z_eff    = origin_q ? 24'sd0 : z_q;
    fine     = 27'sd5898240 - 27'(base_q) - 27'(z_eff);
    psi_full = (fine + 27'sd256) >>> 9;
    dx       = 17'(tx_q) - 17'(goal_x_q);
    dy       = 17'(ty_q) - 17'(goal_y_q);
    dz       = 17'(tz_q) - 17'(goal_z_q);
    omega_neg  = omega_q[33];
    omega_zero = (omega_q == 34'sd0);
    omega_low  = (omega_q < 34'sd62914560);
    rate_mag   = omega_neg ? (34'sd0 - omega_q) : omega_q;
    mid_sum    = 26'(lo_q) + 26'(hi_q);
    speed_sum  = 26'(p_q) + 26'd32768;
    g_val      = 60'(prod >>> 8) - rate_c0_q;
    pan_sum    = 19'sd11584 + 19'(psi_q);
    pan_sh     = 12'(pan_sum >>> 7);
    if (pan_sh < 12'sd0) begin
      pan_clamped = 9'd0;
    end else if (pan_sh > 12'sd360) begin
      pan_clamped = 9'd360;
    end else begin
      pan_clamped = pan_sh[8:0];
    end
  end

  assign sts_o.mul_done    = mul_done;
  assign sts_o.need_search = !omega_zero && (omega_neg || omega_low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      goal_z_q <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN:   gain_q   <= cfg_data_i;
          CFG_GOAL_X: goal_x_q <= cfg_data_i;
          CFG_GOAL_Y: goal_y_q <= cfg_data_i;
          CFG_GOAL_Z: goal_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decide && !omega_zero && !omega_neg && !omega_low) begin
        held_q <= '0;
      end else if (cmd_i.hold_calc) begin
        held_q <= speed_sum[24:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tx_q     <= in_x_i;
      ty_q     <= in_y_i;
      tz_q     <= in_z_i;
      z_q      <= '0;
      origin_q <= (in_x_i == 16'sd0) && (in_y_i == 16'sd0);
      if (!in_y_i[15]) begin
        u_q    <= 32'(in_y_i) <<< 12;
        v_q    <= 32'(in_x_i) <<< 12;
        base_q <= 25'sd0;
      end else begin
        u_q    <= (32'sd0 - 32'(in_y_i)) <<< 12;
        v_q    <= (32'sd0 - 32'(in_x_i)) <<< 12;
        base_q <= in_x_i[15] ? -25'sd11796480 : 25'sd11796480;
      end
    end
    if (cmd_i.cordic_step) begin
      if (v_q[31]) begin
        u_q <= u_q - v_sh;
        v_q <= v_q + u_sh;
        z_q <= z_q - arc;
      end else begin
        u_q <= u_q + v_sh;
        v_q <= v_q - u_sh;
        z_q <= z_q + arc;
      end
    end
    if (cmd_i.psi_calc) begin
      psi_q   <= psi_full[16:0];
      err_z_q <= 34'(dz) <<< 7;
    end
    if (cmd_i.mul_start) begin
      op_q <= cmd_i.mul_op;
    end
    if (mul_done) begin
      case (op_q)
        MUL_OMEGA: omega_q <= 34'sd0 - $signed(prod[33:0]);
        MUL_GYPSI: err_x_q <= (34'(dx) <<< 7) + $signed(prod[33:0]);
        MUL_GXPSI: err_y_q <= (34'(dy) <<< 7) - $signed(prod[33:0]);
        MUL_VX:    vel_x_q <= vel_sat(prod);
        MUL_VY:    vel_y_q <= vel_sat(prod);
        MUL_VZ:    vel_z_q <= vel_sat(prod);
        MUL_C3:    b_q     <= 36'(prod >>> 16) - 36'(K_C2);
        MUL_C2:    c_q     <= 45'(prod >>> 16) + 45'(K_C1);
        MUL_C1: begin
          sg_pos_q <= !g_val[59] && (g_val != 60'sd0);
          sg_neg_q <= g_val[59];
        end
        default: ;
      endcase
    end
    if (cmd_i.decide) begin
      rate_c0_q <= (60'(rate_mag) <<< 21) + K_C0;
      if (omega_zero) begin
        status_q <= TURN_HOLD;
      end else if (omega_neg) begin
        status_q <= TURN_LEFT;
      end else if (omega_low) begin
        status_q <= TURN_RIGHT;
      end else begin
        status_q <= TURN_NONE;
      end
    end
    if (cmd_i.bis_init) begin
      lo_q <= 25'd65536;
      hi_q <= 25'd16777216;
      p_q  <= 25'd16777216;
    end
    if (cmd_i.hi_sign) begin
      hi_pos_q <= sg_pos_q;
      hi_neg_q <= sg_neg_q;
    end
    if (cmd_i.mid_calc) begin
      p_q <= mid_sum[25:1];
    end
    if (cmd_i.bis_update) begin
      // The root lies above the midpoint when the curve changes sign across it.
      if ((hi_pos_q && sg_neg_q) || (hi_neg_q && sg_pos_q)) begin
        lo_q <= p_q;
      end else begin
        hi_q     <= p_q;
        hi_pos_q <= sg_pos_q;
        hi_neg_q <= sg_neg_q;
      end
    end
    if (cmd_i.out_load) begin
      ovx_q    <= vel_x_q;
      ovy_q    <= vel_y_q;
      ovz_q    <= vel_z_q;
      opan_q   <= pan_clamped;
      ospeed_q <= held_q;
      ostat_q  <= status_q;
    end
  end

  assign vel_x_o       = ovx_q;
  assign vel_y_o       = ovy_q;
  assign vel_z_o       = ovz_q;
  assign pan_angle_o   = opan_q;
  assign pan_speed_o   = ospeed_q;
  assign turn_status_o = ostat_q;

endmodule

FILE: hw/rtl/ptc_ctrl.sv
// Controller state machine that sequences the datapath for one target transaction.
module ptc_ctrl import ptc_pkg::*; #(
  parameter int ATAN_STEPS   = 16,
  parameter int BISECT_STEPS = 22
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  ptc_sts_t sts_i,
  output ptc_cmd_t cmd_o
);

  localparam int CntW = ($clog2(BISECT_STEPS) > 5) ? $clog2(BISECT_STEPS) : 5;

  ptc_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            issued_q, issued_d;
  logic            first_q, first_d;
  logic            out_valid_q, out_valid_d;

  function automatic ptc_mul_op_e op_of(input ptc_state_e s);
    case (s)
      ST_OMEGA: op_of = MUL_OMEGA;
      ST_GYPSI: op_of = MUL_GYPSI;
      ST_GXPSI: op_of = MUL_GXPSI;
      ST_VX:    op_of = MUL_VX;
      ST_VY:    op_of = MUL_VY;
      ST_VZ:    op_of = MUL_VZ;
      ST_C3:    op_of = MUL_C3;
      ST_C2:    op_of = MUL_C2;
      ST_C1:    op_of = MUL_C1;
      default:  op_of = MUL_OMEGA;
    endcase
  endfunction

  function automatic ptc_state_e next_of(input ptc_state_e s);
    case (s)
      ST_OMEGA: next_of = ST_GYPSI;
      ST_GYPSI: next_of = ST_GXPSI;
      ST_GXPSI: next_of = ST_VX;
      ST_VX:    next_of = ST_VY;
      ST_VY:    next_of = ST_VZ;
      ST_VZ:    next_of = ST_DECIDE;
      ST_C3:    next_of = ST_C2;
      ST_C2:    next_of = ST_C1;
      default:  next_of = ST_BUPD;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issued_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issued_q    <= issued_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issued_d    = issued_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o            = '0;
    cmd_o.mul_op     = op_of(state_q);
    cmd_o.cordic_idx = cnt_q[4:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == CntW'(ATAN_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_PSI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PSI: begin
        cmd_o.psi_calc = 1'b1;
        state_d        = ST_OMEGA;
      end
      ST_OMEGA, ST_GYPSI, ST_GXPSI, ST_VX, ST_VY, ST_VZ, ST_C3, ST_C2, ST_C1: begin
        if (!issued_q) begin
          cmd_o.mul_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.mul_done) begin
          issued_d = 1'b0;
          if (state_q == ST_C1 && first_q) begin
            state_d = ST_HISGN;
          end else begin
            state_d = next_of(state_q);
          end
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.need_search ? ST_BINIT : ST_OUT;
      end
      ST_BINIT: begin
        cmd_o.bis_init = 1'b1;
        first_d        = 1'b1;
        state_d        = ST_C3;
      end
      ST_HISGN: begin
        cmd_o.hi_sign = 1'b1;
        first_d       = 1'b0;
        cnt_d         = '0;
        state_d       = ST_MID;
      end
      ST_MID: begin
        cmd_o.mid_calc = 1'b1;
        state_d        = ST_C3;
      end
      ST_BUPD: begin
        cmd_o.bis_update = 1'b1;
        if (cnt_q == CntW'(BISECT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_HOLD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_MID;
        end
      end
      ST_HOLD: begin
        cmd_o.hold_calc = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/pan_tilt_tracking_command_top.sv
// Top level of the pan-tilt tracking command block.
// Each target transaction yields one command transaction. The target is
// turned through a CORDIC that retires one rotation per cycle, then a single
// shared multiplier works through the products in turn, serving three products
// for every bisection step of the PWM curve when a pan speed search is needed.
// The next target can be taken in the same cycle that the command becomes
// valid. The finished command sits in an output register, so the next target
// is taken while it waits. Configuration writes are always ready and should be
// made only while the block is idle.
module pan_tilt_tracking_command_top import ptc_pkg::*; #(
  parameter int ATAN_STEPS   = 16,
  parameter int BISECT_STEPS = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ptc_target_if.sink       target_i,
  ptc_command_if.source    command_o,
  ptc_cfg_if.sink          cfg_i
);

  ptc_cmd_t cmd;
  ptc_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  ptc_ctrl #(
    .ATAN_STEPS   (ATAN_STEPS),
    .BISECT_STEPS (BISECT_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (target_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (command_o.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .in_x_i        (target_i.target_x),
    .in_y_i        (target_i.target_y),
    .in_z_i        (target_i.target_z),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .vel_x_o       (command_o.robot_vel_x),
    .vel_y_o       (command_o.robot_vel_y),
    .vel_z_o       (command_o.robot_vel_z),
    .pan_angle_o   (command_o.pan_angle),
    .pan_speed_o   (command_o.pan_speed),
    .turn_status_o (command_o.turn_status)
  );

  assign target_i.ready       = in_ready;
  assign command_o.valid      = out_valid;
  assign command_o.tilt_angle = TILT_ANGLE;
  assign cfg_i.ready          = 1'b1;

`ifndef SYNTHESIS
  // The result returns once low partial, high partial and sum are registered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> ##4 sts.mul_done)
    else $error("multiplier result not returned on time");

  // Once a target is taken, no other is taken until its work has moved on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_i.valid && target_i.ready) |=> !target_i.ready)
    else $error("target taken while busy");

  // A rate beyond the curve always reports a stopped pan motor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (command_o.valid && command_o.turn_status == TURN_NONE) |-> command_o.pan_speed == 9'd0)
    else $error("pan speed not cleared when no solution exists");
`endif

endmodule
